### sv/cfd_pkg.sv
// Shared types and constants for the container frame demultiplexer.
// Depends on nothing; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    // Frame header layout
    localparam int unsigned HDR_LEN   = 12;
    localparam int unsigned HDR_IDX_W = 4;
    localparam int unsigned LEN_W     = 24;
    localparam int unsigned TS_W      = 32;

    // Frame type codes (ASCII)
    localparam logic [7:0] TYPE_VIDEO = 8'h56;
    localparam logic [7:0] TYPE_EXTRA = 8'h44;
    localparam logic [7:0] TYPE_AUDIO = 8'h41;
    localparam logic [7:0] TYPE_SEEKP = 8'h52;

    // Stream select codes
    localparam logic SEL_AUDIO = 1'b0;
    localparam logic SEL_VIDEO = 1'b1;

    // Configuration register indexes
    localparam logic CFG_VIDEO_EN = 1'b0;
    localparam logic CFG_AUDIO_EN = 1'b1;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_VIDEO  = 4'b0010,
        PH_AUDIO  = 4'b0100,
        PH_DROP   = 4'b1000
    } t_phase;

    // One delivered packet byte or empty marker
    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   stream_sel;
        logic                   first_of_packet;
        logic                   last_of_packet;
        logic                   empty_packet;
        logic signed [TS_W-1:0] timestamp;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

### sv/container_frame_demux_top.sv
// Top level of the container frame demultiplexer: front parser, result queue,
// output stage. Depends on cfd_pkg, cfd_front, cfd_queue and cfd_back.
//
// Usage:
//   Input channel: one byte of the frame stream per request on i_data_byte,
//   taken when i_in_valid is high and o_in_stall is low.
//   Output channel: one packet byte (or an empty audio marker) per request
//   on the o_* fields, taken when o_out_valid is high and i_out_stall is low.
//   Header bytes of video/extradata frames and their payload go out with
//   stream select 1; audio payload goes out with stream select 0.
//   The timestamp field carries the frame timestamp on the last byte of a
//   packet and is zero otherwise.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 video
//   enable, 1 audio enable); write only while the block is idle (not enforced).
// Timing:
//   One byte accepted per cycle while o_in_stall is low. A result enters the
//   queue at the edge that accepts its byte, then the output register. The
//   parser updates its counters per accepted byte; the queue of QUEUE_DEPTH
//   entries absorbs receiver stalls; o_in_stall rises only when it is full.
// Reset: synchronous, active low; both enables return to 1, the parser
//   waits for the first header byte and the queue and output are empty.
`timescale 1ns / 1ps
`default_nettype none

module container_frame_demux_top
    import cfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic              i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_stream_sel,
    output logic                   o_first_of_packet,
    output logic                   o_last_of_packet,
    output logic                   o_empty_packet,
    output logic signed [TS_W-1:0] o_timestamp
);

    t_result w_front_res, w_q_data, w_out_res;
    logic    w_push, w_pop, w_full, w_empty, w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    cfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .o_result    (w_front_res),
        .o_push      (w_push)
    );

    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_res),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    cfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_result  (w_out_res)
    );

    // Unpack the output record
    assign o_out_byte        = w_out_res.out_byte;
    assign o_stream_sel      = w_out_res.stream_sel;
    assign o_first_of_packet = w_out_res.first_of_packet;
    assign o_last_of_packet  = w_out_res.last_of_packet;
    assign o_empty_packet    = w_out_res.empty_packet;
    assign o_timestamp       = w_out_res.timestamp;

endmodule

`default_nettype wire

### sv/cfd_front.sv
// Front end: parses the frame byte stream and classifies each byte.
// Uses cfd_pkg; emits at most one result record per accepted byte into the queue.
`timescale 1ns / 1ps
`default_nettype none

module cfd_front
    import cfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic       i_cfg_data,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    output t_result         o_result,
    output logic            o_push
);

    logic                 r_video_en, r_audio_en;
    logic [HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic [7:0]           r_frame_type, n_frame_type;
    logic [TS_W-1:0]      r_frame_ts, n_frame_ts;
    logic [LEN_W-1:0]     r_payload_left, n_payload_left;
    t_phase               r_phase, n_phase;
    logic                 r_to_video, n_to_video;

    logic [HDR_IDX_W-1:0] v_idx;
    logic [LEN_W-1:0]     v_dec;
    logic                 v_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_en <= 1'b1;
            r_audio_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VIDEO_EN: r_video_en <= i_cfg_data;
                CFG_AUDIO_EN: r_audio_en <= i_cfg_data;
                default:      r_video_en <= r_video_en;
            endcase
        end
    end

    // Parse one byte: capture header fields, count payload, build result
    always_comb begin
        n_hdr_idx      = r_hdr_idx;
        n_frame_type   = r_frame_type;
        n_frame_ts     = r_frame_ts;
        n_payload_left = r_payload_left;
        n_phase        = r_phase;
        n_to_video     = r_to_video;
        o_push         = 1'b0;
        o_result       = '0;
        v_idx          = (r_hdr_idx >= HDR_IDX_W'(HDR_LEN)) ? '0 : r_hdr_idx;
        v_dec          = (r_payload_left != '0) ? r_payload_left - LEN_W'(1) : '0;
        v_last         = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                // Capture header fields
                if (v_idx == '0) begin
                    n_frame_type = i_data_byte;
                    n_to_video   = ((i_data_byte == TYPE_VIDEO) ||
                                    (i_data_byte == TYPE_EXTRA)) && r_video_en;
                end else if (v_idx >= HDR_IDX_W'(4) && v_idx <= HDR_IDX_W'(7)) begin
                    unique case (v_idx[1:0])
                        2'd0: n_frame_ts[7:0]   = i_data_byte;
                        2'd1: n_frame_ts[15:8]  = i_data_byte;
                        2'd2: n_frame_ts[23:16] = i_data_byte;
                        2'd3: n_frame_ts[31:24] = i_data_byte;
                        default: n_frame_ts = r_frame_ts;
                    endcase
                end else if (v_idx >= HDR_IDX_W'(8)) begin
                    unique case (v_idx[1:0])
                        2'd0: n_payload_left[7:0]   = i_data_byte;
                        2'd1: n_payload_left[15:8]  = i_data_byte;
                        2'd2: n_payload_left[23:16] = i_data_byte;
                        default: n_payload_left = r_payload_left;
                    endcase
                end

                if (v_idx < HDR_IDX_W'(HDR_LEN - 1)) begin
                    // Mid-header: forward to video if routed there
                    n_hdr_idx                = v_idx + HDR_IDX_W'(1);
                    o_push                   = n_to_video;
                    o_result.out_byte        = i_data_byte;
                    o_result.stream_sel      = SEL_VIDEO;
                    o_result.first_of_packet = (v_idx == '0);
                end else begin
                    // Last header byte: decide what follows
                    n_hdr_idx = '0;
                    if (r_to_video) begin
                        v_last                  = (n_payload_left == '0);
                        n_phase                 = v_last ? PH_HEADER : PH_VIDEO;
                        o_push                  = 1'b1;
                        o_result.out_byte       = i_data_byte;
                        o_result.stream_sel     = SEL_VIDEO;
                        o_result.last_of_packet = v_last;
                        o_result.timestamp      = v_last ? r_frame_ts : '0;
                    end else if (r_frame_type == TYPE_SEEKP) begin
                        n_payload_left = '0;
                        n_phase        = PH_HEADER;
                    end else if (r_frame_type == TYPE_AUDIO && r_audio_en) begin
                        if (n_payload_left == '0) begin
                            n_phase                  = PH_HEADER;
                            o_push                   = 1'b1;
                            o_result.stream_sel      = SEL_AUDIO;
                            o_result.first_of_packet = 1'b1;
                            o_result.last_of_packet  = 1'b1;
                            o_result.empty_packet    = 1'b1;
                            o_result.timestamp       = r_frame_ts;
                        end else begin
                            n_phase = PH_AUDIO;
                        end
                    end else begin
                        n_phase = (n_payload_left == '0) ? PH_HEADER : PH_DROP;
                    end
                end
            end
            PH_VIDEO: begin
                n_payload_left          = v_dec;
                v_last                  = (v_dec == '0);
                n_phase                 = v_last ? PH_HEADER : PH_VIDEO;
                o_push                  = 1'b1;
                o_result.out_byte       = i_data_byte;
                o_result.stream_sel     = SEL_VIDEO;
                o_result.last_of_packet = v_last;
                o_result.timestamp      = v_last ? r_frame_ts : '0;
            end
            PH_AUDIO: begin
                // Header index marks whether the first payload byte went out
                n_payload_left           = v_dec;
                v_last                   = (v_dec == '0);
                n_hdr_idx                = v_last ? '0 : HDR_IDX_W'(1);
                n_phase                  = v_last ? PH_HEADER : PH_AUDIO;
                o_push                   = 1'b1;
                o_result.out_byte        = i_data_byte;
                o_result.stream_sel      = SEL_AUDIO;
                o_result.first_of_packet = (r_hdr_idx == '0);
                o_result.last_of_packet  = v_last;
                o_result.timestamp       = v_last ? r_frame_ts : '0;
            end
            PH_DROP: begin
                n_payload_left = v_dec;
                n_phase        = (v_dec == '0) ? PH_HEADER : PH_DROP;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        o_push = o_push && i_accept;
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx      <= '0;
            r_frame_type   <= '0;
            r_frame_ts     <= '0;
            r_payload_left <= '0;
            r_phase        <= PH_HEADER;
            r_to_video     <= 1'b0;
        end else if (i_accept) begin
            r_hdr_idx      <= n_hdr_idx;
            r_frame_type   <= n_frame_type;
            r_frame_ts     <= n_frame_ts;
            r_payload_left <= n_payload_left;
            r_phase        <= n_phase;
            r_to_video     <= n_to_video;
        end
    end

endmodule

`default_nettype wire

### sv/cfd_queue.sv
// Short result queue between the parser front end and the output stage.
// Uses cfd_pkg for the result record; DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module cfd_queue
    import cfd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_data,
    input  wire logic i_pop,
    output t_result   o_data,
    output logic      o_full,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            priority case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/cfd_back.sv
// Output stage: holds one result record for the receiver, refilled from the queue.
// Uses cfd_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module cfd_back
    import cfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  t_result   i_q_data,
    output logic      o_q_pop,
    input  wire logic i_stall,
    output logic      o_valid,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_result;

    // Load when the register is free or being taken this cycle
    assign o_q_pop  = !i_q_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_q_empty;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_result <= i_q_data;
        end
    end

endmodule

`default_nettype wire
